// ===== rtl/core/c2s_pkg.sv =====
// Shared constants, types and a helper function of the cartesian to spherical converter.
package c2s_pkg;

  localparam int COORD_BITS    = 32;
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 18;

  // Guard bits below the coordinates inside the CORDIC datapath
  localparam int GUARD = 60 - COORD_BITS;

  localparam int SQ_W        = 2 * COORD_BITS;
  localparam int SQ_ROOT_W   = COORD_BITS + GUARD;
  localparam int SQ_RAD_W    = 2 * SQ_ROOT_W;
  localparam int SQ_REM_W    = SQ_ROOT_W + 2;
  localparam int SQ_ACC_W    = SQ_REM_W + 2;
  localparam int SQ_STEPS    = SQ_ROOT_W;

  localparam int CD_W        = 64;
  localparam int CD_STEPS    = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int ACC_W       = 32;
  localparam int STAGE_IDX_W = 5;

  localparam int FRONT_STAGES = 3;
  localparam int SIDE_DEPTH   = SQ_STEPS + CD_STEPS;
  localparam int PIPE_STAGES  = FRONT_STAGES + SIDE_DEPTH + 1;

  localparam int LAT_LIMIT = 2 ** (ANGLE_BITS - 2);

  localparam logic [ACC_W-1:0] QUARTER_TURN       = 32'h4000_0000;
  localparam logic [ACC_W-1:0] HALF_TURN          = 32'h8000_0000;
  localparam logic [ACC_W-1:0] THREE_QUARTER_TURN = 32'hC000_0000;

  localparam int RND_POS = (ANGLE_BITS < ACC_W) ? ACC_W - ANGLE_BITS - 1 : 0;
  localparam logic [ACC_W-1:0] ANGLE_RND =
      (ANGLE_BITS < ACC_W) ? (ACC_W'(1) << RND_POS) : '0;

  // atan(2^-i) in units of 2^32 per turn
  localparam logic [ACC_W-1:0] ATAN_TABLE [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [SQ_RAD_W-1:0]  rad;
    logic [SQ_ROOT_W-1:0] root;
    logic [SQ_REM_W-1:0]  rem;
  } sq_lane_t;

  typedef struct packed {
    logic signed [CD_W-1:0] x;
    logic signed [CD_W-1:0] y;
    logic [ACC_W-1:0]       ang;
  } cd_lane_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]        ax;
    logic [COORD_BITS-1:0]        az;
    logic signed [COORD_BITS-1:0] sy;
    logic                         sx_neg;
    logic                         sy_neg;
    logic                         sz_neg;
    logic                         ax_zero;
    logic                         ay_zero;
    logic                         az_zero;
    logic                         sxy_zero;
    logic                         sum_zero;
    logic [COORD_BITS-1:0]        length;
  } side_t;

  typedef struct packed {
    logic [SQ_W-1:0] sum;
    logic [SQ_W-1:0] sxy;
    side_t           side;
  } front_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]        length;
    logic signed [ANGLE_BITS-1:0] latitude;
    logic [ANGLE_BITS-1:0]        longitude;
    logic                         zero_vector;
  } result_t;

  // Round a full-turn accumulator to the output angle width
  function automatic logic [ANGLE_BITS-1:0] to_angle(input logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0] sum;
    sum = acc + ANGLE_RND;
    return sum[ACC_W-1 -: ANGLE_BITS];
  endfunction

endpackage

// ===== rtl/core/c2s_in_if.sv =====
// Input channel: one cartesian vector per item with valid/ready handshake.
interface c2s_in_if import c2s_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;

  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, output ready);
  modport monitor (input valid, ready, coord_x, coord_y, coord_z);
endinterface

// ===== rtl/core/c2s_out_if.sv =====
// Output channel: one spherical result per item with valid/ready handshake.
interface c2s_out_if import c2s_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [COORD_BITS-1:0]        length;
  logic signed [ANGLE_BITS-1:0] latitude;
  logic [ANGLE_BITS-1:0]        longitude;
  logic                         zero_vector;

  modport source (output valid, length, latitude, longitude, zero_vector, input ready);
  modport sink (input valid, length, latitude, longitude, zero_vector, output ready);
  modport monitor (input valid, ready, length, latitude, longitude, zero_vector);
endinterface

// ===== rtl/core/cartesian_to_spherical.sv =====
// Top level of the cartesian to spherical converter.
// Takes a vector of three signed coordinates and returns its rounded length,
// its latitude and its longitude as binary angles (one full turn is
// 2^ANGLE_BITS units), plus a flag for the all-zero vector, which gives zero
// for everything else. The datapath is a pipeline of 82 stages: three front
// stages (absolute values, squares, sums), two side-by-side chains of 60
// square-root cells that settle one root bit each for the length and for the
// horizontal radius, two side-by-side chains of 18 CORDIC cells that turn the
// latitude and longitude vectors, and an output register. A new item is taken
// in every cycle while the input is ready. Each stage holds its own valid bit,
// so a stalled output only blocks the input once every stage holds an item.
module cartesian_to_spherical import c2s_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  c2s_in_if.sink    coord_i,
  c2s_out_if.source sph_o
);

  logic [PIPE_STAGES-1:0] valid_q, valid_d, valid_in, adv;
  logic [PIPE_STAGES-1:0] stage_rdy;

  front_t                 front;
  sq_lane_t               len_lane [SQ_STEPS+1];
  sq_lane_t               rho_lane [SQ_STEPS+1];
  cd_lane_t               lat_lane [CD_STEPS+1];
  cd_lane_t               lon_lane [CD_STEPS+1];
  cd_lane_t               lat_in, lon_in;
  side_t                  side_q   [SIDE_DEPTH];
  side_t                  side_src [SIDE_DEPTH];
  side_t                  sd_cd, sd_end;

  logic [SQ_ROOT_W-1:0]   len_root;
  logic [COORD_BITS-1:0]  len_round;
  logic signed [CD_W-1:0] sy_g;
  logic [ACC_W-1:0]       lon_acc, lat_ang, lat_clamp, lat_abs, lat_acc;
  result_t                res_d, res_q;

  // Flow control: a stage may load when it is empty or its item moves on
  for (genvar k = 0; k < PIPE_STAGES; k++) begin : g_rdy
    assign stage_rdy[k] = sph_o.ready || !(&valid_q[PIPE_STAGES-1:k]);
  end

  assign adv      = stage_rdy;
  assign valid_in = {valid_q[PIPE_STAGES-2:0], coord_i.valid};
  assign valid_d  = (adv & valid_in) | (~adv & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign coord_i.ready = stage_rdy[0];

  c2s_front u_front (
    .clk_i     (clk_i),
    .en_i      (adv[FRONT_STAGES-1:0]),
    .coord_x_i (coord_i.coord_x),
    .coord_y_i (coord_i.coord_y),
    .coord_z_i (coord_i.coord_z),
    .front_o   (front)
  );

  // Square-root chains: full length and horizontal radius, both scaled by 2^GUARD
  assign len_lane[0] = '{rad: {front.sum, {(2*GUARD){1'b0}}}, root: '0, rem: '0};
  assign rho_lane[0] = '{rad: {front.sxy, {(2*GUARD){1'b0}}}, root: '0, rem: '0};

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    c2s_sqrt_cell u_len_cell (
      .clk_i  (clk_i),
      .en_i   (adv[FRONT_STAGES+j]),
      .lane_i (len_lane[j]),
      .lane_o (len_lane[j+1])
    );
    c2s_sqrt_cell u_rho_cell (
      .clk_i  (clk_i),
      .en_i   (adv[FRONT_STAGES+j]),
      .lane_i (rho_lane[j]),
      .lane_o (rho_lane[j+1])
    );
  end

  // Round the scaled root to the nearest integer
  always_comb begin
    len_root  = len_lane[SQ_STEPS].root;
    len_round = len_root[SQ_ROOT_W-1 -: COORD_BITS]
              + {{(COORD_BITS-1){1'b0}}, len_root[GUARD-1]};
  end

  // Side data travels alongside the lanes
  always_comb begin
    side_src[0] = front.side;
    for (int m = 1; m < SIDE_DEPTH; m++) begin
      side_src[m] = side_q[m-1];
    end
    side_src[SQ_STEPS].length = len_round;
  end

  for (genvar m = 0; m < SIDE_DEPTH; m++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (adv[FRONT_STAGES+m]) begin
        side_q[m] <= side_src[m];
      end
    end
  end

  // CORDIC entry: fold the left half plane over for longitude
  always_comb begin
    sd_cd = side_q[SQ_STEPS-1];
    sy_g  = {{(CD_W-SQ_ROOT_W){sd_cd.sy[COORD_BITS-1]}}, sd_cd.sy, {GUARD{1'b0}}};
    lat_in.x   = CD_W'(rho_lane[SQ_STEPS].root);
    lat_in.y   = CD_W'({sd_cd.az, {GUARD{1'b0}}});
    lat_in.ang = '0;
    lon_in.x   = CD_W'({sd_cd.ax, {GUARD{1'b0}}});
    lon_in.y   = sd_cd.sx_neg ? -sy_g : sy_g;
    lon_in.ang = sd_cd.sx_neg ? HALF_TURN : '0;
  end

  assign lat_lane[0] = lat_in;
  assign lon_lane[0] = lon_in;

  for (genvar j = 0; j < CD_STEPS; j++) begin : g_cordic
    c2s_cordic_cell u_lat_cell (
      .clk_i  (clk_i),
      .en_i   (adv[FRONT_STAGES+SQ_STEPS+j]),
      .step_i (STAGE_IDX_W'(j)),
      .lane_i (lat_lane[j]),
      .lane_o (lat_lane[j+1])
    );
    c2s_cordic_cell u_lon_cell (
      .clk_i  (clk_i),
      .en_i   (adv[FRONT_STAGES+SQ_STEPS+j]),
      .step_i (STAGE_IDX_W'(j)),
      .lane_i (lon_lane[j]),
      .lane_o (lon_lane[j+1])
    );
  end

  // Axis cases, quadrant fix, clamp and sign of latitude
  always_comb begin
    sd_end  = side_q[SIDE_DEPTH-1];
    lat_ang = lat_lane[CD_STEPS].ang;
    if (sd_end.ax_zero && sd_end.ay_zero) begin
      lon_acc = '0;
    end else if (sd_end.ax_zero) begin
      lon_acc = sd_end.sy_neg ? THREE_QUARTER_TURN : QUARTER_TURN;
    end else if (sd_end.ay_zero) begin
      lon_acc = sd_end.sx_neg ? HALF_TURN : '0;
    end else if (!sd_end.sx_neg && !sd_end.sy_neg
                 && (lon_lane[CD_STEPS].ang >= HALF_TURN)) begin
      lon_acc = '0;
    end else begin
      lon_acc = lon_lane[CD_STEPS].ang;
    end

    lat_clamp = (lat_ang > QUARTER_TURN) ? QUARTER_TURN : lat_ang;
    if (sd_end.az_zero) begin
      lat_abs = '0;
    end else if (sd_end.sxy_zero) begin
      lat_abs = QUARTER_TURN;
    end else begin
      lat_abs = lat_clamp;
    end
    lat_acc = sd_end.sz_neg ? -lat_abs : lat_abs;

    res_d.length      = sd_end.length;
    res_d.latitude    = to_angle(lat_acc);
    res_d.longitude   = to_angle(lon_acc);
    res_d.zero_vector = 1'b0;
    if (sd_end.sum_zero) begin
      res_d             = '0;
      res_d.zero_vector = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[PIPE_STAGES-1]) begin
      res_q <= res_d;
    end
  end

  assign sph_o.valid       = valid_q[PIPE_STAGES-1];
  assign sph_o.length      = res_q.length;
  assign sph_o.latitude    = res_q.latitude;
  assign sph_o.longitude   = res_q.longitude;
  assign sph_o.zero_vector = res_q.zero_vector;

endmodule

// ===== rtl/core/c2s_front.sv =====
// Front stages: absolute values, squares and the two sums of squares.
module c2s_front import c2s_pkg::*; (
  input  logic                         clk_i,
  input  logic [FRONT_STAGES-1:0]      en_i,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  input  logic signed [COORD_BITS-1:0] coord_z_i,
  output front_t                       front_o
);

  logic [COORD_BITS-1:0]        ax_d, ay_d, az_d;
  logic [COORD_BITS-1:0]        ax_q, ay_q, az_q;
  logic signed [COORD_BITS-1:0] sy_q;
  logic                         sx_neg_q, sy_neg_q, sz_neg_q;
  logic [SQ_W-1:0]              sqx_d, sqy_d, sqz_d;
  logic [SQ_W-1:0]              sqx_q, sqy_q, sqz_q;
  side_t                        side_d, side_q;
  front_t                       front_d, front_q;

  always_comb begin
    ax_d = coord_x_i[COORD_BITS-1] ? -coord_x_i : coord_x_i;
    ay_d = coord_y_i[COORD_BITS-1] ? -coord_y_i : coord_y_i;
    az_d = coord_z_i[COORD_BITS-1] ? -coord_z_i : coord_z_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ax_q     <= ax_d;
      ay_q     <= ay_d;
      az_q     <= az_d;
      sy_q     <= coord_y_i;
      sx_neg_q <= coord_x_i[COORD_BITS-1];
      sy_neg_q <= coord_y_i[COORD_BITS-1];
      sz_neg_q <= coord_z_i[COORD_BITS-1];
    end
  end

  always_comb begin
    sqx_d = SQ_W'(ax_q) * SQ_W'(ax_q);
    sqy_d = SQ_W'(ay_q) * SQ_W'(ay_q);
    sqz_d = SQ_W'(az_q) * SQ_W'(az_q);
    side_d          = '0;
    side_d.ax       = ax_q;
    side_d.az       = az_q;
    side_d.sy       = sy_q;
    side_d.sx_neg   = sx_neg_q;
    side_d.sy_neg   = sy_neg_q;
    side_d.sz_neg   = sz_neg_q;
    side_d.ax_zero  = (ax_q == '0);
    side_d.ay_zero  = (ay_q == '0);
    side_d.az_zero  = (az_q == '0);
    side_d.sxy_zero = (ax_q == '0) && (ay_q == '0);
    side_d.sum_zero = (ax_q == '0) && (ay_q == '0) && (az_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sqx_q  <= sqx_d;
      sqy_q  <= sqy_d;
      sqz_q  <= sqz_d;
      side_q <= side_d;
    end
  end

  always_comb begin
    front_d.sxy  = sqx_q + sqy_q;
    front_d.sum  = front_d.sxy + sqz_q;
    front_d.side = side_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

// ===== rtl/core/c2s_sqrt_cell.sv =====
// One square-root cell: settles one root bit from the next two radicand bits.
module c2s_sqrt_cell import c2s_pkg::*; (
  input  logic     clk_i,
  input  logic     en_i,
  input  sq_lane_t lane_i,
  output sq_lane_t lane_o
);

  logic [SQ_ACC_W-1:0] acc;
  logic [SQ_ACC_W-1:0] trial;
  logic [SQ_ACC_W:0]   diff;
  logic                take;
  sq_lane_t            lane_d, lane_q;

  always_comb begin
    acc   = {lane_i.rem, lane_i.rad[SQ_RAD_W-1 -: 2]};
    trial = SQ_ACC_W'({lane_i.root, 2'b01});
    diff  = {1'b0, acc} - {1'b0, trial};
    take  = !diff[SQ_ACC_W];
    lane_d.rad  = lane_i.rad << 2;
    lane_d.root = {lane_i.root[SQ_ROOT_W-2:0], take};
    lane_d.rem  = take ? diff[SQ_REM_W-1:0] : acc[SQ_REM_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// ===== rtl/core/c2s_cordic_cell.sv =====
// One CORDIC vectoring cell: rotates toward the x axis by atan(2^-step).
module c2s_cordic_cell import c2s_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [STAGE_IDX_W-1:0] step_i,
  input  cd_lane_t               lane_i,
  output cd_lane_t               lane_o
);

  logic signed [CD_W-1:0] x, y, dx, dy;
  cd_lane_t               lane_d, lane_q;

  always_comb begin
    x  = lane_i.x;
    y  = lane_i.y;
    dx = y >>> step_i;
    dy = x >>> step_i;
    if (!y[CD_W-1]) begin
      lane_d.x   = x + dx;
      lane_d.y   = y - dy;
      lane_d.ang = lane_i.ang + ATAN_TABLE[step_i];
    end else begin
      lane_d.x   = x - dx;
      lane_d.y   = y + dy;
      lane_d.ang = lane_i.ang - ATAN_TABLE[step_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// ===== rtl/core/c2s_checker.sv =====
// Port-level checks of the converter and their binding to the top level.
module c2s_checker import c2s_pkg::*; (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [COORD_BITS-1:0]        length_i,
  input logic signed [ANGLE_BITS-1:0] latitude_i,
  input logic [ANGLE_BITS-1:0]        longitude_i,
  input logic                         zero_vector_i
);

  // Input may only stall when the output is blocked
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled without a blocked output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(length_i)
      && $stable(latitude_i) && $stable(longitude_i)
      && $stable(zero_vector_i)))
    else $error("output item changed while stalled");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((zero_vector_i == (length_i == '0))
      && (!zero_vector_i || ((latitude_i == '0) && (longitude_i == '0)))))
    else $error("zero vector flag disagrees with the result");

  a_lat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (($signed(latitude_i) <= LAT_LIMIT)
      && ($signed(latitude_i) >= -LAT_LIMIT)))
    else $error("latitude beyond a quarter turn");

endmodule

bind cartesian_to_spherical c2s_checker u_c2s_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (coord_i.ready),
  .out_valid_i   (sph_o.valid),
  .out_ready_i   (sph_o.ready),
  .length_i      (sph_o.length),
  .latitude_i    (sph_o.latitude),
  .longitude_i   (sph_o.longitude),
  .zero_vector_i (sph_o.zero_vector)
);

// ===== sim/tb_cartesian_to_spherical.sv =====
// Self-checking testbench for the cartesian to spherical converter.
module tb_cartesian_to_spherical;
  timeunit 1ns;
  timeprecision 1ps;

  import c2s_pkg::*;

  localparam int          GUARD_BITS     = 60 - COORD_BITS;
  localparam int          ROT_STEPS      = 18;
  localparam logic [31:0] TURN_QUARTER   = 32'h4000_0000;
  localparam logic [31:0] TURN_HALF      = 32'h8000_0000;
  localparam logic [31:0] TURN_3QUARTER  = 32'hC000_0000;
  localparam int          LONG_HOLD      = 200;
  localparam int          DRAIN_CYCLES   = 120;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          MAX_REPORTS    = 100;

  localparam logic signed [COORD_BITS-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_BITS-1:0] C_MAX = 32'sh7FFF_FFFF;

  class sphere_checker;
    result_t     pending_results[$];
    int unsigned errors;
    int unsigned reports;

    function new();
      errors  = 0;
      reports = 0;
    endfunction

    // atan(2^-i), 2^32 units per turn
    function logic [31:0] atan_step(int i);
      case (i)
        0:  return 32'h20000000;
        1:  return 32'h12E4051E;
        2:  return 32'h09FB385B;
        3:  return 32'h051111D4;
        4:  return 32'h028B0D43;
        5:  return 32'h0145D7E1;
        6:  return 32'h00A2F61E;
        7:  return 32'h00517C55;
        8:  return 32'h0028BE53;
        9:  return 32'h00145F2F;
        10: return 32'h000A2F98;
        11: return 32'h000517CC;
        12: return 32'h00028BE6;
        13: return 32'h000145F3;
        14: return 32'h0000A2FA;
        15: return 32'h0000517D;
        16: return 32'h000028BE;
        17: return 32'h0000145F;
        default: return 32'h0;
      endcase
    endfunction

    function logic [63:0] root_floor(logic [127:0] n);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (128'(t) * 128'(t) <= n) r = t;
      end
      return r;
    endfunction

    // Turn (x, y) onto the x axis and accumulate the angle
    function logic [31:0] rotate(logic signed [63:0] x, logic signed [63:0] y,
                                 logic [31:0] ang);
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      for (int i = 0; i < ROT_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (!y[63]) begin
          x = x + dx;
          y = y - dy;
          ang = ang + atan_step(i);
        end else begin
          x = x - dx;
          y = y + dy;
          ang = ang - atan_step(i);
        end
      end
      return ang;
    endfunction

    function logic [ANGLE_BITS-1:0] round_angle(logic [31:0] acc);
      logic [31:0] s;
      s = acc + (32'd1 << (31 - ANGLE_BITS));
      return s[31 -: ANGLE_BITS];
    endfunction

    function result_t to_spherical(logic signed [COORD_BITS-1:0] x,
                                   logic signed [COORD_BITS-1:0] y,
                                   logic signed [COORD_BITS-1:0] z);
      logic signed [63:0] sx, sy, sz, xg, yg;
      logic [63:0]        ax, ay, az, len, rho;
      logic [127:0]       sxy, sum, rem;
      logic [31:0]        lon, lat, start;
      result_t            r;
      sx = x;
      sy = y;
      sz = z;
      ax = sx[63] ? -sx : sx;
      ay = sy[63] ? -sy : sy;
      az = sz[63] ? -sz : sz;
      sxy = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
      sum = sxy + 128'(az) * 128'(az);
      r = '0;
      if (sum == 0) begin
        r.zero_vector = 1'b1;
        return r;
      end
      len = root_floor(sum);
      rem = sum - 128'(len) * 128'(len);
      if (rem > 128'(len)) len++;

      if (ax == 0 && ay == 0) lon = '0;
      else if (ax == 0) lon = sy[63] ? TURN_3QUARTER : TURN_QUARTER;
      else if (ay == 0) lon = sx[63] ? TURN_HALF : '0;
      else begin
        xg = sx <<< GUARD_BITS;
        yg = sy <<< GUARD_BITS;
        start = '0;
        // mirror the left half plane onto the right one
        if (sx[63]) begin
          xg = -xg;
          yg = -yg;
          start = TURN_HALF;
        end
        lon = rotate(xg, yg, start);
        // clamp a slightly negative first-quadrant angle
        if (!sx[63] && !sy[63] && lon >= TURN_HALF) lon = '0;
      end

      if (az == 0) lat = '0;
      else begin
        if (sxy == 0) lat = TURN_QUARTER;
        else begin
          rho = root_floor(sxy << (2 * GUARD_BITS));
          lat = rotate(rho, az << GUARD_BITS, '0);
          if (lat > TURN_QUARTER) lat = TURN_QUARTER;
        end
        if (sz[63]) lat = -lat;
      end

      r.length    = len[COORD_BITS-1:0];
      r.latitude  = round_angle(lat);
      r.longitude = round_angle(lon);
      return r;
    endfunction

    function void take_vector(logic signed [COORD_BITS-1:0] x,
                              logic signed [COORD_BITS-1:0] y,
                              logic signed [COORD_BITS-1:0] z);
      pending_results.push_back(to_spherical(x, y, z));
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
      end
    endfunction

    function void check_result(logic [COORD_BITS-1:0] length,
                               logic signed [ANGLE_BITS-1:0] latitude,
                               logic [ANGLE_BITS-1:0] longitude,
                               logic zero_vector);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual length %0d", $time, length);
        return;
      end
      want = pending_results.pop_front();
      compare_field("length", want.length, length);
      compare_field("latitude", want.latitude, latitude);
      compare_field("longitude", want.longitude, longitude);
      compare_field("zero_vector", want.zero_vector, zero_vector);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_n;

  c2s_in_if  coord_if ();
  c2s_out_if sph_if ();

  cartesian_to_spherical uut (
    .clk_i  (clk_i),
    .rst_ni (rst_n),
    .coord_i(coord_if),
    .sph_o  (sph_if)
  );

  sphere_checker board;
  bit            hold_output;
  bit            calm;
  int unsigned   quiet_cycles;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_n === 1'b1) begin
      if (coord_if.valid && coord_if.ready)
        board.take_vector(coord_if.coord_x, coord_if.coord_y, coord_if.coord_z);
      if (sph_if.valid && sph_if.ready)
        board.check_result(sph_if.length, sph_if.latitude, sph_if.longitude,
                           sph_if.zero_vector);
    end
  end

  always @(posedge clk_i) begin
    if ((coord_if.valid && coord_if.ready) || (sph_if.valid && sph_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random stalls, one long hold on request, none once calm
  initial begin
    int unsigned span;
    sph_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_output) begin
        sph_if.ready <= 1'b0;
        span = LONG_HOLD;
        hold_output = 1'b0;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        sph_if.ready <= 1'b1;
        span = $urandom_range(1, 40);
      end else begin
        sph_if.ready <= 1'b0;
        span = $urandom_range(1, 8);
      end
      repeat (span) @(posedge clk_i);
    end
  end

  task automatic send_vector(input logic signed [COORD_BITS-1:0] x,
                             input logic signed [COORD_BITS-1:0] y,
                             input logic signed [COORD_BITS-1:0] z);
    coord_if.valid   <= 1'b1;
    coord_if.coord_x <= x;
    coord_if.coord_y <= y;
    coord_if.coord_z <= z;
    do @(posedge clk_i); while (!coord_if.ready);
  endtask

  // Drop valid and put noise on the coordinates
  task automatic pause_input(input int unsigned cycles);
    coord_if.valid   <= 1'b0;
    coord_if.coord_x <= $urandom();
    coord_if.coord_y <= $urandom();
    coord_if.coord_z <= $urandom();
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic offer(input logic signed [COORD_BITS-1:0] x,
                       input logic signed [COORD_BITS-1:0] y,
                       input logic signed [COORD_BITS-1:0] z);
    send_vector(x, y, z);
    if (!calm && $urandom_range(0, 3) == 0) pause_input($urandom_range(1, 8));
  endtask

  function automatic logic signed [COORD_BITS-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return C_MIN;
      1: return C_MAX;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic logic signed [COORD_BITS-1:0] scaled_coord();
    logic signed [COORD_BITS-1:0] v;
    v = $urandom();
    return v >>> $urandom_range(0, COORD_BITS - 1);
  endfunction

  task automatic random_vector(output logic signed [COORD_BITS-1:0] x,
                               output logic signed [COORD_BITS-1:0] y,
                               output logic signed [COORD_BITS-1:0] z);
    x = $urandom();
    y = $urandom();
    z = $urandom();
    case ($urandom_range(0, 9))
      4: begin
        x = $signed($urandom_range(0, 8)) - 4;
        y = $signed($urandom_range(0, 8)) - 4;
        z = $signed($urandom_range(0, 8)) - 4;
      end
      5: begin
        // single axis
        case ($urandom_range(0, 2))
          0: begin y = 0; z = 0; end
          1: begin x = 0; z = 0; end
          default: begin x = 0; y = 0; end
        endcase
      end
      6: begin
        if ($urandom_range(0, 1) == 0) z = 0;
        else begin x = 0; y = 0; end
      end
      7: begin
        x = scaled_coord();
        y = scaled_coord();
        z = scaled_coord();
      end
      8: begin
        x = pick_extreme();
        y = pick_extreme();
        z = pick_extreme();
      end
      9: begin
        // close to the positive x axis
        x = $urandom_range(1 << 20, 32'h7FFF_FFFF);
        y = $urandom_range(1, 3);
        z = scaled_coord();
      end
      default: ;
    endcase
  endtask

  task automatic random_run(input int unsigned count, input bit no_gaps);
    logic signed [COORD_BITS-1:0] x, y, z;
    repeat (count) begin
      random_vector(x, y, z);
      if (no_gaps) send_vector(x, y, z);
      else offer(x, y, z);
    end
  endtask

  task automatic wait_drained();
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin
    board = new();
    hold_output = 1'b0;
    calm = 1'b0;
    quiet_cycles = 0;
    rst_n            <= 1'b0;
    coord_if.valid   <= 1'b0;
    coord_if.coord_x <= '0;
    coord_if.coord_y <= '0;
    coord_if.coord_z <= '0;
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    offer(0, 0, 0);
    offer(5, 0, 0);
    offer(-5, 0, 0);
    offer(0, 7, 0);
    offer(0, -7, 0);
    offer(0, 0, 9);
    offer(0, 0, -9);
    offer(C_MAX, 0, 0);
    offer(C_MIN, 0, 0);
    offer(0, C_MAX, 0);
    offer(0, C_MIN, 0);
    offer(0, 0, C_MAX);
    offer(0, 0, C_MIN);
    offer(C_MIN, C_MIN, C_MIN);
    offer(C_MAX, C_MAX, C_MAX);
    offer(3, 4, 0);
    offer(1, 1, 1);
    offer(-3, 2, -1);
    offer(-3, -2, 1);
    offer(3, -2, -1);
    offer(C_MAX, 1, 0);
    offer(1, 0, C_MAX);
    offer(0, -1, C_MIN);
    offer(1, 1, C_MIN);
    offer(-1, -1, -1);

    random_run(300, 1'b0);

    // Fill the pipeline against a held output, then wait it out
    hold_output = 1'b1;
    random_run(150, 1'b1);
    pause_input(0);
    wait_drained();

    random_run(200, 1'b0);

    calm = 1'b1;
    random_run(100, 1'b1);
    pause_input(0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
